>>> src/lcube_pkg.sv
// Shared types and constants for the LED cube frame receiver and scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcube_pkg;

  // Item kinds carried on the mode field
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [7:0] SYNC_RESET = 8'hF2;
  localparam logic [7:0] DRIVE_OFF  = 8'hFF;
  localparam logic [7:0] FRONT_INIT = 8'hFF;
  localparam logic [7:0] BACK_INIT  = 8'h00;

  // Per-item result fields, apart from the column byte from the store
  typedef struct packed {
    logic       mode;
    logic [7:0] row_n;
    logic [7:0] layer_n;
    logic       swapped;
  } lcube_side_t;

endpackage

`default_nettype wire

>>> src/lcube_frame_store.sv
// Two-bank frame memory with one write and one registered read port.
// Per-entry valid bits give the reset pattern; uses lcube_pkg.
`default_nettype none

module lcube_frame_store #(
  parameter int AW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [AW:0]   wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW:0]   rd_addr_i,
  output      logic [7:0]    rd_data_o
);
  import lcube_pkg::*;

  localparam int Depth = 2 ** (AW + 1);

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [7:0]       rd_q;
  logic             rd_valid_q;
  logic             rd_bank_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q      <= mem_q[rd_addr_i];
      rd_bank_q <= rd_addr_i[AW];
    end
  end

  // Mark entries once written; reset drops them all back to their initial value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Bank 0 starts as the lit front frame, bank 1 as the dark back frame
  always_comb begin
    if (rd_valid_q) begin
      rd_data_o = rd_q;
    end else if (rd_bank_q) begin
      rd_data_o = BACK_INIT;
    end else begin
      rd_data_o = FRONT_INIT;
    end
  end

endmodule

`default_nettype wire

>>> src/lcube_ctrl.sv
// Frame receiver and scan sequencer: sync detection, write index, bank swap,
// row and layer counters. Uses lcube_pkg; drives lcube_frame_store.
`default_nettype none

module lcube_ctrl #(
  parameter int CUBE_SIDE = 8,
  parameter int AW        = 6,
  parameter int RW        = 3
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  mode_i,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic [7:0]            sync_byte_i,
  output      logic                  wr_en_o,
  output      logic [AW:0]           wr_addr_o,
  output      logic [7:0]            wr_data_o,
  output      logic                  rd_en_o,
  output      logic [AW:0]           rd_addr_o,
  output      lcube_pkg::lcube_side_t side_o
);
  import lcube_pkg::*;

  localparam logic [AW-1:0] LastIdx  = AW'(CUBE_SIDE * CUBE_SIDE - 1);
  localparam logic [RW-1:0] LastScan = RW'(CUBE_SIDE - 1);

  logic          receiving_q, receiving_d;
  logic          front_q, front_d;
  logic [AW-1:0] widx_q, widx_d;
  logic [RW-1:0] row_q, row_d;
  logic [RW-1:0] layer_q, layer_d;
  logic          swapped;
  logic [AW-1:0] scan_idx;

  // Front-frame entry for the current row and layer
  assign scan_idx  = AW'(layer_q) * AW'(CUBE_SIDE) + AW'(row_q);
  assign rd_en_o   = accept_i && (mode_i == MODE_TICK);
  assign rd_addr_o = {front_q, scan_idx};
  assign wr_addr_o = {~front_q, widx_q};
  assign wr_data_o = rx_byte_i;

  // Detect the sync byte, receive bytes into the back frame, swap banks when it is full, and advance the scan position
  always_comb begin
    receiving_d = receiving_q;
    front_d     = front_q;
    widx_d      = widx_q;
    row_d       = row_q;
    layer_d     = layer_q;
    wr_en_o     = 1'b0;
    swapped     = 1'b0;
    if (accept_i) begin
      if (mode_i == MODE_BYTE) begin
        if (!receiving_q) begin
          if (rx_byte_i == sync_byte_i) begin
            receiving_d = 1'b1;
            widx_d      = '0;
          end
        end else begin
          wr_en_o = 1'b1;
          if (widx_q == LastIdx) begin
            front_d     = ~front_q;
            receiving_d = 1'b0;
            widx_d      = '0;
            swapped     = 1'b1;
          end else begin
            widx_d = widx_q + AW'(1);
          end
        end
      end else begin
        if (row_q == LastScan) begin
          row_d = '0;
          if (layer_q == LastScan) begin
            layer_d = '0;
          end else begin
            layer_d = layer_q + RW'(1);
          end
        end else begin
          row_d = row_q + RW'(1);
        end
      end
    end
  end

  // Result fields that do not come from the store
  always_comb begin
    side_o.mode    = mode_i;
    side_o.swapped = swapped;
    if (mode_i == MODE_TICK) begin
      side_o.row_n   = ~(8'd1 << row_q);
      side_o.layer_n = ~(8'd1 << layer_q);
    end else begin
      side_o.row_n   = DRIVE_OFF;
      side_o.layer_n = DRIVE_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      front_q     <= 1'b0;
      widx_q      <= '0;
      row_q       <= '0;
      layer_q     <= '0;
    end else begin
      receiving_q <= receiving_d;
      front_q     <= front_d;
      widx_q      <= widx_d;
      row_q       <= row_d;
      layer_q     <= layer_d;
    end
  end

endmodule

`default_nettype wire

>>> src/led_cube_frame_receiver_and_scanner.sv
// Double-buffered LED cube frame receiver and scan controller.
// A result passes through the store read stage, then the result register. Throughput:
// one item per cycle while the output does not stall, set by the single-port store
// read and the one-deep stage in front of the result register.
// Reset: idle receiver, scan at row 0 layer 0, bank 0 front; every store entry
// reads as its initial value through per-entry valid bits, no clearing pass.
`default_nettype none

module led_cube_frame_receiver_and_scanner #(
  parameter int CUBE_SIDE = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic       mode_i,
  input  wire logic [7:0] rx_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [7:0] column_bits_o,
  output      logic [7:0] row_drive_n_o,
  output      logic [7:0] layer_drive_n_o,
  output      logic       frame_swapped_o
);
  import lcube_pkg::*;

  localparam int AW = $clog2(CUBE_SIDE * CUBE_SIDE);
  localparam int RW = $clog2(CUBE_SIDE);

  logic        accept;
  logic        advance;
  logic [7:0]  sync_q;
  logic        wr_en;
  logic [AW:0] wr_addr;
  logic [7:0]  wr_data;
  logic        rd_en;
  logic [AW:0] rd_addr;
  logic [7:0]  rd_data;
  lcube_side_t side;
  lcube_side_t s1_side_q;
  logic        s1_valid_q;
  logic        out_valid_q;
  logic [7:0]  col_q;
  lcube_side_t out_side_q;

  // Sync byte register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
    end else if (cfg_valid_i) begin
      sync_q <= cfg_data_i;
    end
  end

  // Handshake: read stage moves on when the result register is free or drains
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  lcube_ctrl #(
    .CUBE_SIDE(CUBE_SIDE),
    .AW       (AW),
    .RW       (RW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .mode_i     (mode_i),
    .rx_byte_i  (rx_byte_i),
    .sync_byte_i(sync_q),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .side_o     (side)
  );

  lcube_frame_store #(
    .AW(AW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Read stage: hold the item's side fields alongside the store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_side_q <= side;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_side_q <= s1_side_q;
      col_q      <= (s1_side_q.mode == MODE_TICK) ? rd_data : 8'h00;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign column_bits_o   = col_q;
  assign row_drive_n_o   = out_side_q.row_n;
  assign layer_drive_n_o = out_side_q.layer_n;
  assign frame_swapped_o = out_side_q.swapped;

  // Byte results keep all drives off and the columns dark
  a_byte_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_drive_n_o == DRIVE_OFF |->
      column_bits_o == 8'h00 && layer_drive_n_o == DRIVE_OFF)
    else $error("byte result drives columns or layers");

  // Scan results select exactly one row and one layer and never report a swap
  a_scan_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_drive_n_o != DRIVE_OFF |->
      $onehot(~row_drive_n_o) && $onehot(~layer_drive_n_o) && !frame_swapped_o)
    else $error("scan result with bad row or layer select");

  // An item in the read stage that cannot move on must block the input
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input accepted while read stage is blocked");

endmodule

`default_nettype wire
